// File: hw/rtl/aisp_pkg.sv
// shared types, codes and helper functions of the arcade i/o shift port block
`default_nettype none

package aisp_pkg;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_CONTROL = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    VAR_FULL     = 3'd0,
    VAR_PLAIN    = 3'd1,
    VAR_REV_IN0  = 3'd2,
    VAR_INV_REV  = 3'd3,
    VAR_FIXED0   = 3'd4
  } variant_e;

  typedef enum logic {
    REG_VARIANT = 1'b0,
    REG_DIP     = 1'b1
  } reg_idx_e;

  localparam logic [7:0] CtrlReset   = 8'h08;
  localparam logic [7:0] Port0Full   = 8'h0E;
  localparam logic [7:0] Port0Fixed  = 8'hFF;
  localparam logic [3:0] CtrlCodeMax = 4'd11;

  localparam logic [2:0] PortData0   = 3'd0;
  localparam logic [2:0] PortData1   = 3'd1;
  localparam logic [2:0] PortData2   = 3'd2;
  localparam logic [2:0] PortData3   = 3'd3;
  localparam logic [2:0] PortData4   = 3'd4;
  localparam logic [2:0] PortData5   = 3'd5;

  typedef struct packed {
    logic [3:0] control_code;
    logic [7:0] write_data;
    logic [2:0] port_number;
    req_e       req_type;
  } item_t;

  typedef struct packed {
    logic [7:0] sound_latch_b;
    logic [7:0] sound_latch_a;
    logic [7:0] read_data;
  } result_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] dip_byte(input logic [7:0] d);
    return {d[3], 3'b000, d[5], 1'b0, d[0], d[1]};
  endfunction

  function automatic logic [7:0] ctrl_mask(input logic [2:0] sel);
    logic [7:0] m;
    case (sel)
      3'd0:    m = 8'h01;
      3'd1:    m = 8'h04;
      3'd2:    m = 8'h02;
      3'd3:    m = 8'h10;
      3'd4:    m = 8'h20;
      3'd5:    m = 8'h40;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/aisp_core.sv
// port decode, shifter state, control and sound latches
`default_nettype none

module aisp_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [7:0]        cfg_data_i,
  input  wire logic              step_i,
  input  wire aisp_pkg::item_t   item_i,
  output aisp_pkg::result_t      res_o
);

  logic [2:0]  variant_q;
  logic [7:0]  dip_q;
  logic [15:0] pair_q, pair_d;
  logic [2:0]  amt_q, amt_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  snd_a_q, snd_a_d;
  logic [7:0]  snd_b_q, snd_b_d;

  logic [7:0]  shifted;
  logic [7:0]  rd;
  logic        data_hit;
  logic        off_hit;
  logic [7:0]  mask;

  always_comb begin
    pair_d   = pair_q;
    amt_d    = amt_q;
    ctrl_d   = ctrl_q;
    snd_a_d  = snd_a_q;
    snd_b_d  = snd_b_q;
    rd       = 8'h00;
    data_hit = 1'b0;
    off_hit  = 1'b0;
    mask     = aisp_pkg::ctrl_mask(item_i.control_code[3:1]);
    shifted  = 8'(pair_q >> (4'd8 - {1'b0, amt_q}));

    case (aisp_pkg::variant_e'(variant_q))
      aisp_pkg::VAR_FULL: begin
        data_hit = (item_i.port_number == aisp_pkg::PortData4);
        off_hit  = (item_i.port_number == aisp_pkg::PortData2);
      end
      aisp_pkg::VAR_PLAIN: begin
        data_hit = (item_i.port_number == aisp_pkg::PortData4);
        off_hit  = (item_i.port_number == aisp_pkg::PortData2);
      end
      aisp_pkg::VAR_REV_IN0, aisp_pkg::VAR_FIXED0: begin
        data_hit = (item_i.port_number == aisp_pkg::PortData3);
        off_hit  = (item_i.port_number == aisp_pkg::PortData4);
      end
      aisp_pkg::VAR_INV_REV: begin
        data_hit = (item_i.port_number == aisp_pkg::PortData2);
        off_hit  = (item_i.port_number == aisp_pkg::PortData1);
      end
      default: begin
        data_hit = 1'b0;
        off_hit  = 1'b0;
      end
    endcase

    case (item_i.req_type)
      aisp_pkg::REQ_READ: begin
        case (aisp_pkg::variant_e'(variant_q))
          aisp_pkg::VAR_FULL: begin
            case (item_i.port_number)
              aisp_pkg::PortData0: rd = aisp_pkg::Port0Full;
              aisp_pkg::PortData1: rd = ctrl_q;
              aisp_pkg::PortData2: rd = aisp_pkg::dip_byte(dip_q);
              aisp_pkg::PortData3: rd = shifted;
              default:             rd = 8'h00;
            endcase
          end
          aisp_pkg::VAR_PLAIN: begin
            if (item_i.port_number == aisp_pkg::PortData3) rd = shifted;
          end
          aisp_pkg::VAR_REV_IN0: begin
            if (item_i.port_number == aisp_pkg::PortData0) begin
              rd = aisp_pkg::reverse8(shifted);
            end else if (item_i.port_number == aisp_pkg::PortData3) begin
              rd = shifted;
            end
          end
          aisp_pkg::VAR_INV_REV: begin
            if (item_i.port_number == aisp_pkg::PortData1) begin
              rd = ~shifted;
            end else if (item_i.port_number == aisp_pkg::PortData3) begin
              rd = aisp_pkg::reverse8(shifted);
            end
          end
          aisp_pkg::VAR_FIXED0: begin
            if (item_i.port_number == aisp_pkg::PortData0) begin
              rd = aisp_pkg::Port0Fixed;
            end else if (item_i.port_number == aisp_pkg::PortData3) begin
              rd = shifted;
            end
          end
          default: rd = 8'h00;
        endcase
      end
      aisp_pkg::REQ_WRITE: begin
        if (variant_q == aisp_pkg::VAR_FULL) begin
          if (item_i.port_number == aisp_pkg::PortData3) snd_a_d = item_i.write_data;
          if (item_i.port_number == aisp_pkg::PortData5) snd_b_d = item_i.write_data;
        end
        if (data_hit) begin
          pair_d = {item_i.write_data, pair_q[15:8]};
        end else if (off_hit) begin
          amt_d = item_i.write_data[2:0];
        end
      end
      aisp_pkg::REQ_CONTROL: begin
        if (variant_q == aisp_pkg::VAR_FULL &&
            item_i.control_code <= aisp_pkg::CtrlCodeMax) begin
          if (!item_i.control_code[0]) ctrl_d = ctrl_q | mask;
          else                         ctrl_d = ctrl_q & ~mask;
        end
      end
      default: rd = 8'h00;
    endcase
  end

  assign res_o.read_data     = rd;
  assign res_o.sound_latch_a = snd_a_d;
  assign res_o.sound_latch_b = snd_b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 3'd0;
      dip_q     <= 8'h00;
      pair_q    <= 16'h0000;
      amt_q     <= 3'd0;
      ctrl_q    <= aisp_pkg::CtrlReset;
      snd_a_q   <= 8'h00;
      snd_b_q   <= 8'h00;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == aisp_pkg::REG_VARIANT) variant_q <= cfg_data_i[2:0];
        else                                    dip_q     <= cfg_data_i;
      end
      if (step_i) begin
        pair_q  <= pair_d;
        amt_q   <= amt_d;
        ctrl_q  <= ctrl_d;
        snd_a_q <= snd_a_d;
        snd_b_q <= snd_b_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.req_type != aisp_pkg::REQ_READ) |-> (res_o.read_data == 8'h00))
    else $error("nonzero read data for a non-read item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.req_type != aisp_pkg::REQ_CONTROL) |=> $stable(ctrl_q))
    else $error("control bits changed without a control event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(pair_q) && $stable(amt_q) && $stable(snd_a_q) && $stable(snd_b_q)))
    else $error("shifter or sound state changed with no item");

endmodule

`default_nettype wire

// File: hw/rtl/arcade_io_shift_port_block.sv
// top level of the arcade i/o shift port block: input and result registers around the core
`default_nettype none

// Port i/o board with a barrel shift register. Each input item is a port read, a port
// write or a control event (tuser = req_type); each gives exactly one result item with
// the read byte and both sound latches as they stand after the item. An item passes
// through the input register and then the result register; the block takes one item per
// cycle while the result side takes each result. The result register is refilled while its
// item is being taken. Configuration (index 0 board variant, index 1 dip switches) is
// to be written by the user while no item is in flight; the block does not enforce this.
// cfg_ready_o is always high.
module arcade_io_shift_port_block (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // port_number, write_data, control_code
  input  wire logic [1:0]  s_axis_tuser_i,   // req_type
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // read_data, sound_latch_a, sound_latch_b
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  logic              in_valid_q;
  aisp_pkg::item_t   in_item_q;
  logic              out_valid_q;
  aisp_pkg::result_t out_res_q;
  aisp_pkg::result_t core_res;
  logic              adv;
  logic              s_fire;

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire)   in_valid_q <= 1'b1;
      else if (adv) in_valid_q <= 1'b0;
      if (adv)                  out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q.req_type     <= aisp_pkg::req_e'(s_axis_tuser_i);
      in_item_q.port_number  <= s_axis_tdata_i[2:0];
      in_item_q.write_data   <= s_axis_tdata_i[10:3];
      in_item_q.control_code <= s_axis_tdata_i[14:11];
    end
    if (adv) out_res_q <= core_res;
  end

  aisp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (adv),
    .item_i     (in_item_q),
    .res_o      (core_res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |-> adv)
    else $error("item held in input register with empty result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i && !adv) |=> $stable(out_res_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire
